@@ hw/rtl/fcebp_pkg.sv @@
// Shared types and constants of the front-coded entry block parser.
// No dependencies; compile first.
`default_nettype none

package fcebp_pkg;

  localparam int unsigned OFS_W = 31;

  localparam logic [15:0] CNT_WIDE_FLAG = 16'h8000;
  localparam logic [15:0] LEN16_MASK    = 16'h7fff;

  // Parser phase, one-hot
  typedef enum logic [8:0] {
    PH_CNT_LO  = 9'b000000001,
    PH_CNT_HI  = 9'b000000010,
    PH_LEN     = 9'b000000100,
    PH_PREFIX  = 9'b000001000,
    PH_ATTR_AL = 9'b000010000,
    PH_TAIL    = 9'b000100000,
    PH_ATTR_UN = 9'b001000000,
    PH_DATA    = 9'b010000000,
    PH_DONE    = 9'b100000000
  } phase_t;

  // Result word kinds
  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_HW_BYTE  = 3'd1,
    KIND_HW_END   = 3'd2,
    KIND_ATTR     = 3'd3,
    KIND_DATA     = 3'd4
  } kind_t;

  // Status from the length assembler
  typedef struct packed {
    logic             complete;  // this byte finishes the length field
    logic             zero16;    // finished 16-bit length is zero
    logic [OFS_W-1:0] len_cur;   // stored (sanitized) length
    logic [OFS_W-1:0] len_new;   // sanitized length after this byte
  } len_info_t;

endpackage

`default_nettype wire

@@ hw/rtl/fcebp_if.sv @@
// Valid/ready channel interfaces: raw block bytes in, parsed result words out.
// Depends on fcebp_pkg.
`default_nettype none

interface fcebp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_last;

  modport source (output valid, output data_byte, output block_last, input ready);
  modport sink   (input valid, input data_byte, input block_last, output ready);
endinterface

interface fcebp_result_if
  import fcebp_pkg::*;
;
  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [7:0]       byte_value;
  logic [OFS_W-1:0] position;
  logic [OFS_W-1:0] entry_offset;
  logic             entry_last;

  modport source (output valid, output kind, output byte_value, output position,
                  output entry_offset, output entry_last, input ready);
  modport sink   (input valid, input kind, input byte_value, input position,
                  input entry_offset, input entry_last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fcebp_len_asm.sv @@
// Entry length assembler: collects 2 or 4 little-endian length bytes.
// Depends on fcebp_pkg.
`default_nettype none

module fcebp_len_asm
  import fcebp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic       clear,
  input  wire logic       wide,
  input  wire logic [7:0] byte_in,
  output len_info_t       info
);

  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] shifted;
  logic [31:0] sanitized;
  logic        complete;

  assign shifted  = acc_r | ({24'd0, byte_in} << {idx_r, 3'b000});
  assign complete = (idx_r == (wide ? 2'd3 : 2'd1));

  // negative lengths read as zero
  always_comb begin
    if (wide) begin
      sanitized = shifted[31] ? 32'd0 : shifted;
    end else begin
      sanitized = ((shifted[15:0] & CNT_WIDE_FLAG) != 16'd0) ? 32'd0
                : {16'd0, shifted[15:0] & LEN16_MASK};
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    idx_nxt = idx_r;
    if (clear) begin
      acc_nxt = '0;
      idx_nxt = '0;
    end else if (step) begin
      if (complete) begin
        acc_nxt = sanitized;
        idx_nxt = '0;
      end else begin
        acc_nxt = shifted;
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      idx_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign info.complete = complete;
  assign info.zero16   = !wide && (shifted[15:0] == 16'd0);
  assign info.len_cur  = acc_r[OFS_W-1:0];
  assign info.len_new  = sanitized[OFS_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/front_coded_entry_block_parser.sv @@
// Front-coded entry block parser, top level.
// Depends on fcebp_pkg, fcebp_if (both interfaces) and fcebp_len_asm.
// Usage:
//   in_ch  : one raw block byte per word, count word first, block_last on
//            the final byte of the block. After that byte the parser starts
//            over at the count word of the next block.
//   out_ch : at most one result word per input byte: entry header, headword
//            tail byte (tagged with its full headword index), headword end,
//            attribute, or data byte. entry_last marks an entry's last word.
//   cfg_we / cfg_wdata : aligned_layout (1 = attribute right after prefix
//            count). Write only while the block is idle.
// Timing: one byte accepted per cycle while in_ch.ready is high. A result is
//   written into the output register as its byte is accepted; bytes that
//   give no result (count word, length bytes, overlong headword bytes, bytes
//   past the end of parsing) just update the state.
// Stall: the output register is the only buffer. in_ch.ready is high while
//   that register is empty or being drained, so a stalled receiver holds
//   the sender after at most one pending word.
// Reset (rst_n, synchronous, active low): parser back to the count word,
//   all counters cleared, aligned_layout = 0, output register empty.
`default_nettype none

module front_coded_entry_block_parser
  import fcebp_pkg::*;
#(
  parameter int unsigned HEADWORD_MAX = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  fcebp_byte_if.sink        in_ch,
  fcebp_result_if.source    out_ch,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata
);

  localparam int unsigned HW_W = $clog2(HEADWORD_MAX);
  localparam logic [HW_W-1:0] HW_LIMIT = HW_W'(HEADWORD_MAX - 1);
  localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};

  // config
  logic aligned_r;

  // parser state
  phase_t           phase_r, phase_nxt;
  logic             wide_r, wide_nxt;
  logic [OFS_W-1:0] rem_r, rem_nxt;
  logic [HW_W-1:0]  hw_idx_r, hw_idx_nxt;
  logic [OFS_W-1:0] data_ofs_r, data_ofs_nxt;
  logic [OFS_W-1:0] blk_ofs_r, blk_ofs_nxt;
  logic [OFS_W-1:0] ent_ofs_r, ent_ofs_nxt;

  // output register
  logic             out_valid_r;
  kind_t            kind_r;
  logic [7:0]       val_r;
  logic [OFS_W-1:0] pos_r;
  logic [OFS_W-1:0] eofs_r;
  logic             elast_r;

  // result of this byte
  logic             emit;
  kind_t            emit_kind;
  logic [7:0]       emit_val;
  logic [OFS_W-1:0] emit_pos;
  logic             emit_last;

  logic             fire;
  logic             len_step, len_clear;
  len_info_t        len_info;
  logic [7:0]       b;
  logic [OFS_W-1:0] rem_dec;
  logic [OFS_W-1:0] hw_pos;
  logic             ends_here;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  assign rem_dec   = (rem_r == '0) ? '0 : rem_r - OFS_W'(1);
  assign ends_here = (rem_dec == '0);
  assign hw_pos    = {{(OFS_W-HW_W){1'b0}}, hw_idx_r};

  fcebp_len_asm u_len (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (len_step),
    .clear   (len_clear),
    .wide    (wide_r),
    .byte_in (b),
    .info    (len_info)
  );

  always_comb begin
    phase_nxt    = phase_r;
    wide_nxt     = wide_r;
    rem_nxt      = rem_r;
    hw_idx_nxt   = hw_idx_r;
    data_ofs_nxt = data_ofs_r;
    blk_ofs_nxt  = blk_ofs_r;
    ent_ofs_nxt  = ent_ofs_r;
    len_step     = 1'b0;
    len_clear    = 1'b0;
    emit         = 1'b0;
    emit_kind    = KIND_HEADER;
    emit_val     = 8'd0;
    emit_pos     = '0;
    emit_last    = 1'b0;

    if (fire) begin
      case (phase_r)
        PH_CNT_LO: begin
          phase_nxt = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          wide_nxt  = b[7];
          len_clear = 1'b1;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_step = 1'b1;
          if (len_info.complete) begin
            if (len_info.zero16) begin
              phase_nxt = PH_DONE;
            end else begin
              rem_nxt   = len_info.len_new;
              phase_nxt = PH_PREFIX;
            end
          end
        end
        PH_PREFIX: begin
          ent_ofs_nxt = blk_ofs_r;
          hw_idx_nxt  = HW_W'(b);
          emit        = 1'b1;
          emit_kind   = KIND_HEADER;
          emit_val    = b;
          emit_pos    = len_info.len_cur;
          phase_nxt   = aligned_r ? PH_ATTR_AL : PH_TAIL;
        end
        PH_ATTR_AL: begin
          emit      = 1'b1;
          emit_kind = KIND_ATTR;
          emit_val  = b;
          phase_nxt = PH_TAIL;
        end
        PH_TAIL: begin
          rem_nxt = rem_dec;
          if (b != 8'd0) begin
            // bytes past the headword limit are dropped
            if (hw_idx_r < HW_LIMIT) begin
              emit       = 1'b1;
              emit_kind  = KIND_HW_BYTE;
              emit_val   = b;
              emit_pos   = hw_pos;
              hw_idx_nxt = hw_idx_r + HW_W'(1);
            end
          end else begin
            emit      = 1'b1;
            emit_kind = KIND_HW_END;
            emit_pos  = hw_pos;
            if (aligned_r) begin
              emit_last = ends_here;
              if (ends_here) begin
                phase_nxt = wide_r ? PH_DONE : PH_LEN;
                len_clear = 1'b1;
              end else begin
                phase_nxt    = PH_DATA;
                data_ofs_nxt = '0;
              end
            end else begin
              phase_nxt = PH_ATTR_UN;
            end
          end
        end
        PH_ATTR_UN: begin
          rem_nxt   = rem_dec;
          emit      = 1'b1;
          emit_kind = KIND_ATTR;
          emit_val  = b;
          emit_last = ends_here;
          if (ends_here) begin
            phase_nxt = wide_r ? PH_DONE : PH_LEN;
            len_clear = 1'b1;
          end else begin
            phase_nxt    = PH_DATA;
            data_ofs_nxt = '0;
          end
        end
        PH_DATA: begin
          rem_nxt   = rem_dec;
          emit      = 1'b1;
          emit_kind = KIND_DATA;
          emit_val  = b;
          emit_pos  = data_ofs_r;
          emit_last = ends_here;
          if (data_ofs_r != OFS_MAX) begin
            data_ofs_nxt = data_ofs_r + OFS_W'(1);
          end
          if (ends_here) begin
            phase_nxt = wide_r ? PH_DONE : PH_LEN;
            len_clear = 1'b1;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase

      if (blk_ofs_r != OFS_MAX) begin
        blk_ofs_nxt = blk_ofs_r + OFS_W'(1);
      end

      // block end: start over at the count word
      if (in_ch.block_last) begin
        phase_nxt    = PH_CNT_LO;
        wide_nxt     = 1'b0;
        len_clear    = 1'b1;
        rem_nxt      = '0;
        hw_idx_nxt   = '0;
        data_ofs_nxt = '0;
        blk_ofs_nxt  = '0;
        ent_ofs_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aligned_r   <= 1'b0;
      phase_r     <= PH_CNT_LO;
      wide_r      <= 1'b0;
      rem_r       <= '0;
      hw_idx_r    <= '0;
      data_ofs_r  <= '0;
      blk_ofs_r   <= '0;
      ent_ofs_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        aligned_r <= cfg_wdata;
      end
      phase_r    <= phase_nxt;
      wide_r     <= wide_nxt;
      rem_r      <= rem_nxt;
      hw_idx_r   <= hw_idx_nxt;
      data_ofs_r <= data_ofs_nxt;
      blk_ofs_r  <= blk_ofs_nxt;
      ent_ofs_r  <= ent_ofs_nxt;
      if (fire) begin
        out_valid_r <= emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: entry offset is the value after this byte's prefix update, before any block-end clear
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      kind_r  <= emit_kind;
      val_r   <= emit_val;
      pos_r   <= emit_pos;
      eofs_r  <= (phase_r == PH_PREFIX) ? blk_ofs_r : ent_ofs_r;
      elast_r <= emit_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.byte_value   = val_r;
  assign out_ch.position     = pos_r;
  assign out_ch.entry_offset = eofs_r;
  assign out_ch.entry_last   = elast_r;

endmodule

`default_nettype wire

@@ test/front_coded_entry_block_parser_tb.sv @@
// Testbench for front_coded_entry_block_parser: sends dictionary data blocks and checks
// every parsed result word against a built-in predictor. Depends on fcebp_pkg, fcebp_if and the parser.
`timescale 1ns / 1ps

module front_coded_entry_block_parser_tb;
  import fcebp_pkg::*;

  localparam int unsigned HW_MAX    = 1024;
  localparam bit [31:0]   OFS_LIMIT = 32'h7fff_ffff;

  // one expected result word
  typedef struct {
    kind_t            kind;
    logic [7:0]       byte_value;
    logic [OFS_W-1:0] position;
    logic [OFS_W-1:0] entry_offset;
    logic             entry_last;
  } parse_word_t;

  typedef bit [7:0] byte_q_t [$];

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  fcebp_byte_if   in_ch ();
  fcebp_result_if out_ch ();

  front_coded_entry_block_parser #(
    .HEADWORD_MAX(HW_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Parser state as the predictor sees it
  // ---------------------------------------------------------------------------
  bit          layout_aligned;
  phase_t      ph;
  bit          wide;
  bit [31:0]   len_acc;
  bit [1:0]    len_idx;
  bit [31:0]   field_left;
  bit [31:0]   hw_idx;
  bit [31:0]   data_ofs;
  bit [31:0]   blk_ofs;
  bit [31:0]   entry_ofs;

  parse_word_t expected_words [$];
  parse_word_t want;
  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned idle_pct;   // sender gap chance per word, percent
  int unsigned stall_pct;  // receiver stall chance per cycle, percent

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous cap, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("front_coded_entry_block_parser_tb NOT OK");
    $finish;
  end

  function automatic void restart_parser();
    ph         = PH_CNT_LO;
    wide       = 1'b0;
    len_acc    = '0;
    len_idx    = '0;
    field_left = '0;
    hw_idx     = '0;
    data_ofs   = '0;
    blk_ofs    = '0;
    entry_ofs  = '0;
  endfunction

  function automatic void expect_word(kind_t k, bit [7:0] v, bit [31:0] pos, bit fin);
    parse_word_t w;
    w.kind         = k;
    w.byte_value   = v;
    w.position     = pos[OFS_W-1:0];
    w.entry_offset = entry_ofs[OFS_W-1:0];
    w.entry_last   = fin;
    expected_words.push_back(w);
  endfunction

  // Narrow blocks go back to the next length field, a wide block holds one entry.
  function automatic void finish_entry();
    ph      = wide ? PH_DONE : PH_LEN;
    len_acc = '0;
    len_idx = '0;
  endfunction

  function automatic void take_field_byte();
    if (field_left != 0) field_left--;
  endfunction

  // Headword end (aligned) or attribute (unaligned): entry ends here if the
  // field is used up, else the data bytes follow.
  function automatic void close_head(kind_t k, bit [7:0] v, bit [31:0] pos);
    bit fin;
    fin = (field_left == 0);
    if (fin) begin
      finish_entry();
    end else begin
      ph       = PH_DATA;
      data_ofs = '0;
    end
    expect_word(k, v, pos, fin);
  endfunction

  // Advance the predicted parser by one accepted word.
  function automatic void parse_byte(bit [7:0] b, bit blk_end);
    bit        fin;
    bit [31:0] pos;
    case (ph)
      PH_CNT_LO: begin
        ph = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        wide    = b[7];   // bit 15 of the count word
        len_acc = '0;
        len_idx = '0;
        ph      = PH_LEN;
      end
      PH_LEN: begin
        len_acc |= 32'(b) << (len_idx * 8);
        if (len_idx == (wide ? 2'd3 : 2'd1)) begin
          len_idx = '0;
          if (!wide && len_acc == 0) begin
            ph = PH_DONE;   // zero 16-bit length ends the entry list
          end else begin
            // negative lengths are taken as zero
            if (wide ? len_acc[31] : len_acc[15]) len_acc = '0;
            field_left = len_acc;
            ph         = PH_PREFIX;
          end
        end else begin
          len_idx++;
        end
      end
      PH_PREFIX: begin
        entry_ofs = blk_ofs;
        hw_idx    = 32'(b);
        ph        = layout_aligned ? PH_ATTR_AL : PH_TAIL;
        expect_word(KIND_HEADER, b, len_acc, 1'b0);
      end
      PH_ATTR_AL: begin
        ph = PH_TAIL;
        expect_word(KIND_ATTR, b, '0, 1'b0);
      end
      PH_TAIL: begin
        take_field_byte();
        if (b != 0) begin
          // bytes past the headword limit are swallowed silently
          if (hw_idx < HW_MAX - 1) begin
            expect_word(KIND_HW_BYTE, b, hw_idx, 1'b0);
            hw_idx++;
          end
        end else if (layout_aligned) begin
          close_head(KIND_HW_END, 8'h00, hw_idx);
        end else begin
          ph = PH_ATTR_UN;
          expect_word(KIND_HW_END, 8'h00, hw_idx, 1'b0);
        end
      end
      PH_ATTR_UN: begin
        take_field_byte();
        close_head(KIND_ATTR, b, '0);
      end
      PH_DATA: begin
        take_field_byte();
        pos = data_ofs;
        fin = (field_left == 0);
        if (data_ofs < OFS_LIMIT) data_ofs++;
        if (fin) finish_entry();
        expect_word(KIND_DATA, b, pos, fin);
      end
      default: begin
        ph = PH_DONE;
      end
    endcase
    if (blk_ofs < OFS_LIMIT) blk_ofs++;
    if (blk_end) restart_parser();
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: mismatch: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind=%0d value=%02h pos=%0d ofs=%0d last=%0b",
                                out_ch.kind, out_ch.byte_value, out_ch.position,
                                out_ch.entry_offset, out_ch.entry_last));
      end else begin
        want = expected_words.pop_front();
        if (out_ch.kind !== want.kind || out_ch.byte_value !== want.byte_value ||
            out_ch.position !== want.position || out_ch.entry_offset !== want.entry_offset ||
            out_ch.entry_last !== want.entry_last) begin
          flag_mismatch($sformatf(
            "expected kind=%0d value=%02h pos=%0d ofs=%0d last=%0b, got %0d %02h %0d %0d %0b",
            want.kind, want.byte_value, want.position, want.entry_offset, want.entry_last,
            out_ch.kind, out_ch.byte_value, out_ch.position, out_ch.entry_offset,
            out_ch.entry_last));
        end
      end
    end
  end

  // Receiver: ready drops in random bursts while stall_pct is nonzero.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sending
  // ---------------------------------------------------------------------------
  // valid stays high across back-to-back words; only a gap or a drain lowers it.
  task automatic send_byte(input bit [7:0] b, input bit blk_end);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.block_last <= blk_end;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    parse_byte(b, blk_end);
    words_sent++;
  endtask

  task automatic send_block(input byte_q_t blk);
    foreach (blk[i]) send_byte(blk[i], i == blk.size() - 1);
  endtask

  // Hold the sender until every result is out and words that produce nothing
  // have passed as well.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_layout(input bit v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    layout_aligned = v;
  endtask

  // ---------------------------------------------------------------------------
  // Block building
  // ---------------------------------------------------------------------------
  function automatic void start_block(ref byte_q_t blk, input bit wide_len);
    blk.delete();
    blk.push_back(8'($urandom));
    blk.push_back({wide_len, 7'($urandom)});
  endfunction

  // Field length that exactly covers the entry in the current layout.
  function automatic int unsigned fit_len(int unsigned tail_len, int unsigned data_len);
    return tail_len + 1 + data_len + (layout_aligned ? 0 : 1);
  endfunction

  function automatic void put_entry(ref byte_q_t blk, input bit wide_len, input bit [31:0] flen,
                                    input bit [7:0] prefix, input int unsigned tail_len,
                                    input int unsigned data_len);
    for (int i = 0; i < (wide_len ? 4 : 2); i++) blk.push_back(flen[8*i +: 8]);
    blk.push_back(prefix);
    if (layout_aligned) blk.push_back(8'($urandom));
    repeat (tail_len) blk.push_back(8'($urandom_range(1, 255)));
    blk.push_back(8'h00);
    if (!layout_aligned) blk.push_back(8'($urandom));
    repeat (data_len) blk.push_back(8'($urandom));
  endfunction

  function automatic void end_list(ref byte_q_t blk, input int unsigned junk);
    blk.push_back(8'h00);
    blk.push_back(8'h00);
    repeat (junk) blk.push_back(8'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  task automatic test_narrow_entries();
    byte_q_t blk;
    write_layout(1'b0);
    start_block(blk, 1'b0);
    put_entry(blk, 1'b0, fit_len(3, 4), 8'h00, 3, 4);
    put_entry(blk, 1'b0, fit_len(0, 0), 8'hff, 0, 0);  // ends on its attribute
    end_list(blk, 2);                                  // bytes after the end give nothing
    blk[blk.size() - 1] = 8'hff;
    blk[blk.size() - 2] = 8'h00;
    send_block(blk);
  endtask

  task automatic test_aligned_entries();
    byte_q_t blk;
    write_layout(1'b1);
    start_block(blk, 1'b0);
    put_entry(blk, 1'b0, fit_len(2, 3), 8'h07, 2, 3);
    put_entry(blk, 1'b0, fit_len(1, 0), 8'h80, 1, 0);  // ends on headword end
    end_list(blk, 1);
    send_block(blk);
  endtask

  task automatic test_wide_entry();
    byte_q_t blk;
    start_block(blk, 1'b1);
    put_entry(blk, 1'b1, fit_len(2, 3), 8'h10, 2, 3);
    repeat (3) blk.push_back(8'($urandom));  // parsing is over after the one entry
    send_block(blk);
  endtask

  // Negative lengths read as zero: no data bytes follow.
  task automatic test_negative_lengths();
    byte_q_t blk;
    start_block(blk, 1'b0);
    put_entry(blk, 1'b0, 32'h0000_8003, 8'h01, 1, 0);
    end_list(blk, 0);
    send_block(blk);
    start_block(blk, 1'b1);
    put_entry(blk, 1'b1, 32'h8000_0010, 8'h02, 1, 0);
    send_block(blk);
  endtask

  // Field shorter than the tail: remaining count sticks at zero.
  task automatic test_short_field();
    byte_q_t blk;
    for (int v = 0; v < 2; v++) begin
      write_layout(v[0]);
      start_block(blk, 1'b0);
      put_entry(blk, 1'b0, 32'd2, 8'h05, 5, 0);
      end_list(blk, 0);
      send_block(blk);
    end
  endtask

  // Headword running past HW_MAX - 1: extra tail bytes are dropped and the
  // reported length saturates.
  task automatic test_long_headword();
    byte_q_t blk;
    write_layout(1'b0);
    start_block(blk, 1'b0);
    put_entry(blk, 1'b0, fit_len(770, 2), 8'hff, 770, 2);
    end_list(blk, 0);
    send_block(blk);
  endtask

  // Block cut inside an entry, next block right behind it.
  task automatic test_cut_block();
    byte_q_t blk;
    start_block(blk, 1'b0);
    put_entry(blk, 1'b0, fit_len(2, 6), 8'h03, 2, 6);
    blk = blk[0 : blk.size() - 4];
    send_block(blk);
    start_block(blk, 1'b0);
    put_entry(blk, 1'b0, fit_len(1, 1), 8'h04, 1, 1);
    end_list(blk, 0);
    send_block(blk);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly well-formed blocks, some broken or pure noise
  // ---------------------------------------------------------------------------
  task automatic send_random_block();
    byte_q_t     blk;
    int unsigned pick;
    int unsigned tl;
    int unsigned dl;
    bit [31:0]   flen;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      blk.delete();
      repeat ($urandom_range(1, 30)) blk.push_back(8'($urandom));
    end else if (pick < 30) begin
      start_block(blk, 1'b1);
      tl   = $urandom_range(0, 8);
      dl   = $urandom_range(0, 10);
      flen = fit_len(tl, dl);
      if ($urandom_range(0, 9) == 0) flen = $urandom;
      put_entry(blk, 1'b1, flen, 8'($urandom), tl, dl);
      repeat ($urandom_range(0, 3)) blk.push_back(8'($urandom));
    end else begin
      start_block(blk, 1'b0);
      repeat ($urandom_range(1, 4)) begin
        tl   = $urandom_range(0, 8);
        dl   = $urandom_range(0, 10);
        flen = fit_len(tl, dl);
        pick = $urandom_range(0, 99);
        if (pick < 10) flen = $urandom_range(0, flen + 3);
        else if (pick < 13) flen = {16'h0, 1'b1, 15'($urandom)};
        put_entry(blk, 1'b0, flen, 8'($urandom), tl, dl);
      end
      if ($urandom_range(0, 4) != 0) end_list(blk, $urandom_range(0, 3));
    end
    if ($urandom_range(0, 9) == 0 && blk.size() > 1) begin
      blk = blk[0 : $urandom_range(0, blk.size() - 2)];
    end
    send_block(blk);
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    for (int p = 0; p < 6; p++) begin
      // register alternates at first, then goes random; the last phase runs
      // with no gaps or stalls at all
      write_layout(p < 2 ? p[0] : 1'($urandom_range(0, 1)));
      idle_pct  = (p == 5) ? 0 : 20 * $urandom_range(0, 2);
      stall_pct = (p == 5) ? 0 : 20 * $urandom_range(0, 2);
      target = words_sent + 12;
      while (words_sent < target) send_random_block();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.block_last <= 1'b0;
    mismatch_count = 0;
    words_sent     = 0;
    idle_pct       = 20;
    stall_pct      = 20;
    layout_aligned = 1'b0;
    restart_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_narrow_entries();
    test_aligned_entries();
    test_wide_entry();
    test_negative_lengths();
    test_short_field();
    test_long_headword();
    test_cut_block();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("front_coded_entry_block_parser_tb OK");
    end else begin
      $display("front_coded_entry_block_parser_tb NOT OK");
    end
    $finish;
  end

endmodule
